// ===== rtl/dpsc_pkg.sv =====
// Package for the deadband proportional step controller.
// Holds widths, register indexes, reset values and fixed constants.
// No dependencies.
package dpsc_pkg;

	// field and state widths
	localparam int ERR_W      = 17;  // angle error, Q8.8 signed
	localparam int STEP_W     = 17;  // drive step, Q8.8 signed
	localparam int PEND_W     = 24;  // pending turn, Q15.8 signed
	localparam int TURN_W     = 18;  // one step's turn, Q9.8 signed
	localparam int FRAC_W     = 17;  // step fraction and ceiling, Q1.16
	localparam int U16_W      = 16;
	localparam int MODE_W     = 3;
	localparam int HOLD_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	// shared multiplier
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int LO_W    = 21;               // low slice of the first product
	localparam int HI_W    = MUL_P_W - LO_W;   // high slice of the first product
	localparam int LO_P_W  = LO_W + U16_W;
	localparam int HI_P_W  = HI_W + U16_W;
	localparam int TOT_W   = HI_P_W + LO_W + 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_FRACTION    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRACTION_CEILING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNITS_PER_DEGREE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_UNIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_CAP         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_BITS        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PENDING_DECAY    = 3'd7;

	// reset values
	localparam logic [FRAC_W-1:0] RST_STEP_FRACTION    = 17'd64618;
	localparam logic [FRAC_W-1:0] RST_FRACTION_CEILING = 17'd65536;
	localparam logic [U16_W-1:0]  RST_UNITS_PER_DEGREE = 16'd2560;
	localparam logic [U16_W-1:0]  RST_DEG_PER_UNIT     = 16'd6554;
	localparam logic [U16_W-1:0]  RST_STEP_CAP         = 16'd13824;
	localparam logic [MODE_W-1:0] RST_MODE_BITS        = 3'd2;
	localparam logic [HOLD_W-1:0] RST_HOLD_TICKS       = 4'd0;
	localparam logic [U16_W-1:0]  RST_PENDING_DECAY    = 16'd39750;

	// mode bit positions
	localparam int MODE_COMP = 0;  // compensate pending turn
	localparam int MODE_REV  = 1;  // zero the effective error on sign reversal
	localparam int MODE_ACK  = 2;  // release the hold gate early on error movement

	// deadband: 5*|error| below this gives a zero step (0.15 degree in Q8.8)
	localparam logic [19:0] DEADBAND_LIM = 20'd192;

endpackage

// ===== rtl/dpsc_ifs.sv =====
// Handshake channels of the deadband proportional step controller.
// Uses dpsc_pkg for the payload widths.

interface dpsc_err_if;
	logic                              valid;
	logic                              ready;
	logic signed [dpsc_pkg::ERR_W-1:0] angle_error;

	modport source(output valid, output angle_error, input ready);
	modport sink(input valid, input angle_error, output ready);
endinterface

interface dpsc_step_if;
	logic                               valid;
	logic                               ready;
	logic signed [dpsc_pkg::STEP_W-1:0] drive_step;
	logic                               held;

	modport source(output valid, output drive_step, output held, input ready);
	modport sink(input valid, input drive_step, input held, output ready);
endinterface

// ===== rtl/deadband_proportional_step_controller_unit.sv =====
// Top level of the deadband proportional step controller.
// Depends on dpsc_pkg and on the channels in dpsc_ifs.sv.
//
//  channel    dir  handshake     payload
//  err_in     in   valid/ready   angle_error (17b signed, Q8.8 deg)
//  step_out   out  valid/ready   drive_step (17b signed, Q8.8 units), held (1b)
//  cfg        in   cfg_write     cfg_index (3b), cfg_data (17b), no read-back
//
// One word goes from acceptance to a filled output register through decay
// (only with pending compensation), gate, effective error, three passes through
// the shared 24x17 multiplier plus a sum, turn product and update, and finish.
// A held word or one inside the deadband finishes right after the gate.
// Every product goes through the single multiplier.
// err_in.ready is high only while the sequencer is idle; the output register
// lets the next word enter while a result still waits on step_out.
// arst_n clears the sequencer, controller state and output valid; presets cfg.
module deadband_proportional_step_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	dpsc_err_if.sink                            err_in,
	dpsc_step_if.source                         step_out,
	input  logic                                cfg_write,
	input  logic [dpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dpsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECAY    = 4'd1;
	localparam logic [3:0] S_DECAY_WB = 4'd2;
	localparam logic [3:0] S_GATE     = 4'd3;
	localparam logic [3:0] S_EFF      = 4'd4;
	localparam logic [3:0] S_MUL1     = 4'd5;
	localparam logic [3:0] S_MUL2     = 4'd6;
	localparam logic [3:0] S_MUL3     = 4'd7;
	localparam logic [3:0] S_SUM      = 4'd8;
	localparam logic [3:0] S_MUL4     = 4'd9;
	localparam logic [3:0] S_TURN     = 4'd10;
	localparam logic [3:0] S_FIN      = 4'd11;

	// configuration registers
	logic [dpsc_pkg::FRAC_W-1:0] step_fraction_q, fraction_ceiling_q;
	logic [dpsc_pkg::U16_W-1:0]  units_per_degree_q, deg_per_unit_q, step_cap_q;
	logic [dpsc_pkg::U16_W-1:0]  pending_decay_q;
	logic [dpsc_pkg::MODE_W-1:0] mode_bits_q;
	logic [dpsc_pkg::HOLD_W-1:0] hold_ticks_q;

	// controller state
	logic signed [dpsc_pkg::PEND_W-1:0] pending_q;
	logic [dpsc_pkg::HOLD_W-1:0]        wait_count_q;
	logic signed [dpsc_pkg::TURN_W-1:0] wait_turn_q;
	logic signed [dpsc_pkg::ERR_W-1:0]  error_at_wait_q;

	// working registers
	logic [3:0]                         state_q;
	logic signed [dpsc_pkg::ERR_W-1:0]  err_q;
	logic [dpsc_pkg::MUL_A_W-1:0]       eff_mag_q;
	logic                               neg_q;
	logic                               held_q;
	logic [dpsc_pkg::U16_W-1:0]         step_mag_q;
	logic [dpsc_pkg::MUL_P_W-1:0]       prod_q;
	logic [dpsc_pkg::HI_W-1:0]          hi_q;
	logic [dpsc_pkg::LO_P_W-1:0]        lo_q;

	// output register
	logic                               out_valid_q;
	logic signed [dpsc_pkg::STEP_W-1:0] out_step_q;
	logic                               out_held_q;

	// shared multiplier
	logic [dpsc_pkg::MUL_A_W-1:0] mul_a;
	logic [dpsc_pkg::MUL_B_W-1:0] mul_b;
	logic [dpsc_pkg::MUL_P_W-1:0] mul_p;

	// datapath signals
	logic                               in_fire, out_fire, out_free;
	logic [dpsc_pkg::PEND_W-1:0]        pend_mag;
	logic [dpsc_pkg::FRAC_W-1:0]        kk;
	logic [dpsc_pkg::PEND_W:0]          decay_sum;
	logic [dpsc_pkg::PEND_W-1:0]        decay_mag;
	logic [dpsc_pkg::ERR_W-1:0]         err_mag;
	logic [19:0]                        err_mag5;
	logic                               in_deadband;
	logic [dpsc_pkg::HOLD_W-1:0]        wc_dec;
	logic signed [dpsc_pkg::ERR_W:0]    moved;
	logic [dpsc_pkg::ERR_W:0]           moved_mag;
	logic [dpsc_pkg::TURN_W-1:0]        wt_mag;
	logic [20:0]                        moved5, wt2;
	logic                               opposite, release_early, gate_open;
	logic signed [dpsc_pkg::PEND_W:0]   eff;
	logic                               eff_zero;
	logic [dpsc_pkg::PEND_W:0]          eff_abs;
	logic [dpsc_pkg::TOT_W-1:0]         total;
	logic [dpsc_pkg::TOT_W-1:0]         total_rnd;
	logic [dpsc_pkg::TOT_W-25:0]        step_rnd;
	logic [dpsc_pkg::U16_W-1:0]         step_clamped;
	logic [32:0]                        turn_sum;
	logic [dpsc_pkg::TURN_W-1:0]        turn_mag;
	logic signed [dpsc_pkg::TURN_W-1:0] turn;
	logic signed [dpsc_pkg::PEND_W:0]   pend_sum;
	logic signed [dpsc_pkg::PEND_W-1:0] pend_sat;

	assign in_fire  = err_in.valid && err_in.ready;
	assign out_fire = out_valid_q && step_out.ready;
	assign out_free = !out_valid_q || step_out.ready;

	assign err_in.ready        = (state_q == S_IDLE);
	assign step_out.valid      = out_valid_q;
	assign step_out.drive_step = out_step_q;
	assign step_out.held       = out_held_q;

	assign kk = (step_fraction_q < fraction_ceiling_q) ? step_fraction_q : fraction_ceiling_q;

	// magnitude of pending turn: at most 2^23, fits 24 bits unsigned
	assign pend_mag = pending_q[dpsc_pkg::PEND_W-1] ? (~pending_q + 1'b1) : pending_q;

	// operand selection for the one multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DECAY: begin
				mul_a = pend_mag;
				mul_b = {1'b0, pending_decay_q};
			end
			S_MUL1: begin
				mul_a = eff_mag_q;
				mul_b = kk;
			end
			S_MUL2: begin
				mul_a = {{(dpsc_pkg::MUL_A_W-dpsc_pkg::LO_W){1'b0}}, prod_q[dpsc_pkg::LO_W-1:0]};
				mul_b = {1'b0, units_per_degree_q};
			end
			S_MUL3: begin
				mul_a = {{(dpsc_pkg::MUL_A_W-dpsc_pkg::HI_W){1'b0}}, hi_q};
				mul_b = {1'b0, units_per_degree_q};
			end
			S_MUL4: begin
				mul_a = {{(dpsc_pkg::MUL_A_W-dpsc_pkg::U16_W){1'b0}}, step_mag_q};
				mul_b = {1'b0, deg_per_unit_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// decay writeback: round the magnitude, ties away from zero
	assign decay_sum = prod_q[dpsc_pkg::PEND_W+15:15] + 25'd1;
	assign decay_mag = decay_sum[dpsc_pkg::PEND_W:1];

	// deadband test
	assign err_mag     = err_q[dpsc_pkg::ERR_W-1] ? (~err_q + 1'b1) : err_q;
	assign err_mag5    = {1'b0, err_mag, 2'b00} + {3'b000, err_mag};
	assign in_deadband = err_mag5 < dpsc_pkg::DEADBAND_LIM;

	// hold gate
	assign wc_dec    = wait_count_q - 1'b1;
	assign moved     = {err_q[dpsc_pkg::ERR_W-1], err_q}
		- {error_at_wait_q[dpsc_pkg::ERR_W-1], error_at_wait_q};
	assign moved_mag = moved[dpsc_pkg::ERR_W] ? (~moved + 1'b1) : moved;
	assign wt_mag    = wait_turn_q[dpsc_pkg::TURN_W-1] ? (~wait_turn_q + 1'b1) : wait_turn_q;
	assign moved5    = {1'b0, moved_mag, 2'b00} + {3'b000, moved_mag};
	assign wt2       = {2'b00, wt_mag, 1'b0};
	assign opposite  = (moved[dpsc_pkg::ERR_W] && !wait_turn_q[dpsc_pkg::TURN_W-1]
			&& (wait_turn_q != '0))
		|| (!moved[dpsc_pkg::ERR_W] && (moved != '0) && wait_turn_q[dpsc_pkg::TURN_W-1]);
	assign release_early = mode_bits_q[dpsc_pkg::MODE_ACK] && opposite && (moved5 >= wt2);

	always_comb begin
		if (hold_ticks_q == '0) begin
			gate_open = 1'b1;
		end else if (wait_count_q == '0) begin
			gate_open = 1'b1;
		end else if (release_early) begin
			gate_open = 1'b1;
		end else begin
			gate_open = (wc_dec == '0);
		end
	end

	// effective error, zeroed on sign reversal when enabled
	always_comb begin
		eff = {err_q[dpsc_pkg::ERR_W-1], {(dpsc_pkg::PEND_W-dpsc_pkg::ERR_W+1){err_q[dpsc_pkg::ERR_W-1]}},
			err_q[dpsc_pkg::ERR_W-2:0]};
		if (mode_bits_q[dpsc_pkg::MODE_COMP]) begin
			eff = eff - {pending_q[dpsc_pkg::PEND_W-1], pending_q};
		end
	end

	assign eff_zero = mode_bits_q[dpsc_pkg::MODE_COMP] && mode_bits_q[dpsc_pkg::MODE_REV]
		&& ((eff[dpsc_pkg::PEND_W] && !err_q[dpsc_pkg::ERR_W-1] && (err_q != '0))
		|| (!eff[dpsc_pkg::PEND_W] && (eff != '0) && err_q[dpsc_pkg::ERR_W-1]));
	assign eff_abs  = eff[dpsc_pkg::PEND_W] ? (~eff + 1'b1) : eff;

	// recombine the split product, round off 24 bits and clamp to the cap
	assign total     = {prod_q[dpsc_pkg::HI_P_W-1:0], {dpsc_pkg::LO_W{1'b0}}}
		+ {{(dpsc_pkg::TOT_W-dpsc_pkg::LO_P_W){1'b0}}, lo_q};
	assign total_rnd = total + {{(dpsc_pkg::TOT_W-24){1'b0}}, 1'b1, 23'd0};
	assign step_rnd  = total_rnd[dpsc_pkg::TOT_W-1:24];
	assign step_clamped = (step_rnd > {{(dpsc_pkg::TOT_W-24-dpsc_pkg::U16_W){1'b0}}, step_cap_q})
		? step_cap_q : step_rnd[dpsc_pkg::U16_W-1:0];

	// turn of this step and the saturated pending update
	assign turn_sum = prod_q[32:0] + 33'h0_0000_8000;
	assign turn_mag = {1'b0, turn_sum[32:16]};
	assign turn     = neg_q ? (~turn_mag + 1'b1) : turn_mag;
	assign pend_sum = {pending_q[dpsc_pkg::PEND_W-1], pending_q}
		+ {{(dpsc_pkg::PEND_W-dpsc_pkg::TURN_W+1){turn[dpsc_pkg::TURN_W-1]}}, turn};

	always_comb begin
		if (pend_sum[dpsc_pkg::PEND_W] != pend_sum[dpsc_pkg::PEND_W-1]) begin
			pend_sat = pend_sum[dpsc_pkg::PEND_W]
				? {1'b1, {(dpsc_pkg::PEND_W-1){1'b0}}}
				: {1'b0, {(dpsc_pkg::PEND_W-1){1'b1}}};
		end else begin
			pend_sat = pend_sum[dpsc_pkg::PEND_W-1:0];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_fraction_q    <= dpsc_pkg::RST_STEP_FRACTION;
			fraction_ceiling_q <= dpsc_pkg::RST_FRACTION_CEILING;
			units_per_degree_q <= dpsc_pkg::RST_UNITS_PER_DEGREE;
			deg_per_unit_q     <= dpsc_pkg::RST_DEG_PER_UNIT;
			step_cap_q         <= dpsc_pkg::RST_STEP_CAP;
			mode_bits_q        <= dpsc_pkg::RST_MODE_BITS;
			hold_ticks_q       <= dpsc_pkg::RST_HOLD_TICKS;
			pending_decay_q    <= dpsc_pkg::RST_PENDING_DECAY;
		end else if (cfg_write) begin
			case (cfg_index)
				dpsc_pkg::REG_STEP_FRACTION:    step_fraction_q    <= cfg_data;
				dpsc_pkg::REG_FRACTION_CEILING: fraction_ceiling_q <= cfg_data;
				dpsc_pkg::REG_UNITS_PER_DEGREE: units_per_degree_q <= cfg_data[dpsc_pkg::U16_W-1:0];
				dpsc_pkg::REG_DEG_PER_UNIT:     deg_per_unit_q     <= cfg_data[dpsc_pkg::U16_W-1:0];
				dpsc_pkg::REG_STEP_CAP:         step_cap_q         <= cfg_data[dpsc_pkg::U16_W-1:0];
				dpsc_pkg::REG_MODE_BITS:        mode_bits_q        <= cfg_data[dpsc_pkg::MODE_W-1:0];
				dpsc_pkg::REG_HOLD_TICKS:       hold_ticks_q       <= cfg_data[dpsc_pkg::HOLD_W-1:0];
				dpsc_pkg::REG_PENDING_DECAY:    pending_decay_q    <= cfg_data[dpsc_pkg::U16_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			pending_q       <= '0;
			wait_count_q    <= '0;
			wait_turn_q     <= '0;
			error_at_wait_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			// load a finished word, else drop the one taken downstream
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= mode_bits_q[dpsc_pkg::MODE_COMP] ? S_DECAY : S_GATE;
					end
				end
				S_DECAY: begin
					state_q <= S_DECAY_WB;
				end
				S_DECAY_WB: begin
					// restore the sign of the decayed magnitude
					pending_q <= pending_q[dpsc_pkg::PEND_W-1] ? (~decay_mag + 1'b1) : decay_mag;
					state_q   <= S_GATE;
				end
				S_GATE: begin
					if (hold_ticks_q != '0) begin
						if (wait_count_q == '0) begin
							wait_count_q    <= hold_ticks_q;
							error_at_wait_q <= err_q;
						end else if (!release_early) begin
							wait_count_q <= wc_dec;
						end
					end
					// held or inside the deadband: drop straight to a zero step
					if (!gate_open || in_deadband) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_EFF;
					end
				end
				S_EFF:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_SUM;
				S_SUM:  state_q <= S_MUL4;
				S_MUL4: state_q <= S_TURN;
				S_TURN: begin
					if (mode_bits_q[dpsc_pkg::MODE_COMP]) begin
						pending_q <= pend_sat;
					end
					if ((hold_ticks_q != '0) && (wait_count_q != '0)) begin
						wait_turn_q <= turn;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// wait for the output register to free up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					err_q <= err_in.angle_error;
				end
			end
			S_DECAY: prod_q <= mul_p;
			S_GATE: begin
				held_q     <= !gate_open;
				step_mag_q <= '0;
				neg_q      <= 1'b0;
			end
			S_EFF: begin
				eff_mag_q <= eff_zero ? '0 : eff_abs[dpsc_pkg::PEND_W-1:0];
				neg_q     <= eff_zero ? 1'b0 : eff[dpsc_pkg::PEND_W];
			end
			S_MUL1: prod_q <= mul_p;
			S_MUL2: begin
				hi_q   <= prod_q[dpsc_pkg::MUL_P_W-1:dpsc_pkg::LO_W];
				prod_q <= mul_p;
			end
			S_MUL3: begin
				lo_q   <= prod_q[dpsc_pkg::LO_P_W-1:0];
				prod_q <= mul_p;
			end
			S_SUM:  step_mag_q <= step_clamped;
			S_MUL4: prod_q <= mul_p;
			S_FIN: begin
				if (out_free) begin
					out_step_q <= neg_q ? (~{1'b0, step_mag_q} + 1'b1) : {1'b0, step_mag_q};
					out_held_q <= held_q;
				end
			end
			default: begin
			end
		endcase
	end

	// a new word always enters the decay or the gate step
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_DECAY || state_q == S_GATE))
		else $error("accepted word did not start the sequence");

	// a held result carries no drive
	a_held_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_held_q) |-> (out_step_q == '0))
		else $error("held result with nonzero drive step");

	// the drive step never exceeds the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_step_q <= $signed({1'b0, step_cap_q}))
			&& (out_step_q >= -$signed({1'b0, step_cap_q}))))
		else $error("drive step beyond cap");

	// a finished word lands in a free output register on the next edge
	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished word not loaded into output register");

endmodule
